// ----- rtl/core/ssv_pkg.sv -----
package ssv_pkg;

   // event kinds carried on the request tuser
   localparam logic [2:0] KIND_SET_COUNT = 3'd0;
   localparam logic [2:0] KIND_FOLLOW    = 3'd1;
   localparam logic [2:0] KIND_UP        = 3'd2;
   localparam logic [2:0] KIND_DOWN      = 3'd3;
   localparam logic [2:0] KIND_TICK      = 3'd4;
   localparam logic [2:0] KIND_HOME      = 3'd5;
   localparam logic [2:0] KIND_END       = 3'd6;
   localparam logic [2:0] KIND_JUMP      = 3'd7;

   localparam int unsigned KIND_WIDTH    = 3;
   localparam int unsigned FIELD_WIDTH   = 16;
   localparam int unsigned HEIGHT_WIDTH  = 8;
   localparam int unsigned REQ_DATA_WIDTH = 16;
   localparam int unsigned RSP_DATA_WIDTH = 56;
   localparam logic [HEIGHT_WIDTH-1:0] HEIGHT_RESET = 8'd24;

   // tick step: distance shifted right, clamped to 1..STEP_MAX
   localparam int unsigned STEP_SHIFT = 2;
   localparam int unsigned STEP_MAX   = 16;

   typedef struct packed {
      logic changed;
      logic following;
      logic pending;
   } ssv_flags_type;

endpackage

// ----- rtl/core/ssv_update.sv -----
module ssv_update #(
   parameter int unsigned LINE_BITS = 16
) (
   input  logic [2:0]              kind,
   input  logic [LINE_BITS-1:0]    value,
   input  logic [LINE_BITS-1:0]    total,
   input  logic [LINE_BITS-1:0]    shown,
   input  logic [LINE_BITS-1:0]    goal,
   input  logic                    tail,
   output logic [LINE_BITS-1:0]    total_next,
   output logic [LINE_BITS-1:0]    shown_next,
   output logic [LINE_BITS-1:0]    goal_next,
   output ssv_pkg::ssv_flags_type  flags
);
   import ssv_pkg::*;

   logic                 tot_nz;
   logic [LINE_BITS-1:0] last;
   logic [LINE_BITS-1:0] val_last;
   logic [LINE_BITS-1:0] room;
   logic [LINE_BITS-1:0] gap;
   logic [LINE_BITS-1:0] gap_sh;
   logic [LINE_BITS-1:0] step;
   logic                 tail_next;
   logic                 changed;

   assign tot_nz   = (total != '0);
   assign last     = total - LINE_BITS'(1);
   assign val_last = value - LINE_BITS'(1);
   assign room     = (goal <= last) ? (last - goal) : '0;
   assign gap      = (shown < goal) ? (goal - shown) : (shown - goal);
   assign gap_sh   = gap >> STEP_SHIFT;

   always_comb begin
      if (gap_sh == '0) begin
         step = LINE_BITS'(1);
      end else if (gap_sh > LINE_BITS'(STEP_MAX)) begin
         step = LINE_BITS'(STEP_MAX);
      end else begin
         step = gap_sh;
      end
   end

   always_comb begin
      total_next = total;
      shown_next = shown;
      goal_next  = goal;
      tail_next  = tail;
      changed    = 1'b0;
      unique case (kind)
         KIND_SET_COUNT: begin
            total_next = value;
            if (value == '0) begin
               shown_next = '0;
               goal_next  = '0;
               tail_next  = 1'b1;
            end else if (tail) begin
               shown_next = val_last;
               goal_next  = val_last;
            end else begin
               if (shown > val_last) shown_next = val_last;
               if (goal > val_last) goal_next = val_last;
            end
            changed = (shown_next != shown);
         end
         KIND_FOLLOW: begin
            tail_next = 1'b1;
            if (tot_nz) begin
               shown_next = last;
               goal_next  = last;
            end
         end
         KIND_UP: begin
            if (tot_nz) begin
               tail_next = 1'b0;
               goal_next = (goal > value) ? (goal - value) : '0;
               changed   = (shown != goal_next);
            end
         end
         KIND_DOWN: begin
            if (tot_nz) begin
               goal_next = goal + ((value < room) ? value : room);
               tail_next = (shown == goal_next) && (goal_next == last);
               changed   = (shown != goal_next);
            end
         end
         KIND_TICK: begin
            if (shown < goal) begin
               shown_next = shown + step;
            end else if (shown > goal) begin
               shown_next = shown - step;
            end
            if ((shown_next == goal) && tot_nz && (shown_next == last)) tail_next = 1'b1;
            changed = (shown_next != shown);
         end
         KIND_HOME: begin
            changed    = (shown != '0);
            tail_next  = 1'b0;
            shown_next = '0;
            goal_next  = '0;
         end
         KIND_END: begin
            changed   = tot_nz && (shown != last);
            tail_next = 1'b1;
            if (tot_nz) begin
               shown_next = last;
               goal_next  = last;
            end
         end
         KIND_JUMP: begin
            if (tot_nz) begin
               shown_next = (value < last) ? value : last;
               goal_next  = shown_next;
               tail_next  = 1'b0;
               changed    = (shown != shown_next);
            end
         end
         default: begin
            changed = 1'b0;
         end
      endcase
   end

   assign flags.changed   = changed;
   assign flags.following = tail_next;
   assign flags.pending   = (shown_next != goal_next);

endmodule

// ----- rtl/core/ssv_window.sv -----
module ssv_window #(
   parameter int unsigned LINE_BITS = 16
) (
   input  logic [LINE_BITS-1:0]                total,
   input  logic [LINE_BITS-1:0]                shown,
   input  logic [ssv_pkg::HEIGHT_WIDTH-1:0]    height,
   output logic [LINE_BITS-1:0]                win_begin,
   output logic [LINE_BITS-1:0]                win_end
);
   import ssv_pkg::*;

   logic [LINE_BITS-1:0] h;
   logic [LINE_BITS-1:0] half;
   logic [LINE_BITS-1:0] lim;
   logic [LINE_BITS-1:0] start;
   logic [LINE_BITS-1:0] start_lim;

   assign h         = LINE_BITS'(height);
   assign half      = h >> 1;
   assign lim       = total - h;
   assign start     = (shown > half) ? (shown - half) : '0;
   assign start_lim = (start > lim) ? lim : start;

   always_comb begin
      win_begin = '0;
      win_end   = '0;
      if ((total != '0) && (h != '0)) begin
         // small buffer shows everything
         if (total <= h) begin
            win_end = total;
         end else begin
            win_begin = start_lim;
            win_end   = start_lim + h;
         end
      end
   end

endmodule

// ----- rtl/core/smooth_scroll_viewport_core.sv -----
// pipeline: a result passes the stage 1 registers and then the output register before it is valid
// throughput: one item per cycle while rsp is not stalled; the state update (clamp, scroll, step)
// is done ahead of the state registers, the window math sits in the following stage
// backpressure on rsp stalls req through a combinational ready chain
// reset: empty buffer, lines at 0, tail following on, window height 24, no result held
module smooth_scroll_viewport_core #(
   parameter int unsigned LINE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ssv_pkg::HEIGHT_WIDTH-1:0]    csr_wr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ssv_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,  // value_in[15:0]
   input  logic [ssv_pkg::KIND_WIDTH-1:0]      req_tuser,  // kind[2:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // changed[0], shown line[16:1], follow flag[17], pending flag[18],
   // window_begin[34:19], window_end[50:35], zero[55:51]
   output logic [ssv_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);
   import ssv_pkg::*;

   logic [HEIGHT_WIDTH-1:0] height_ff;
   logic [LINE_BITS-1:0]    total_ff;
   logic [LINE_BITS-1:0]    shown_ff;
   logic [LINE_BITS-1:0]    goal_ff;
   logic                    tail_ff;

   logic [LINE_BITS-1:0]    total_in;
   logic [LINE_BITS-1:0]    shown_in;
   logic [LINE_BITS-1:0]    goal_in;
   ssv_flags_type           flags_in;

   logic                    s1_valid_ff;
   logic [LINE_BITS-1:0]    s1_total_ff;
   logic [LINE_BITS-1:0]    s1_shown_ff;
   ssv_flags_type           s1_flags_ff;

   logic                    out_valid_ff;
   logic [RSP_DATA_WIDTH-1:0] out_data_ff;
   logic [RSP_DATA_WIDTH-1:0] out_data_in;

   logic [LINE_BITS-1:0]    win_begin;
   logic [LINE_BITS-1:0]    win_end;
   logic                    s2_ready;
   logic                    accept;

   assign s2_ready   = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign accept     = req_tvalid && req_tready;

   ssv_update #(.LINE_BITS(LINE_BITS)) u_update (
      .kind       (req_tuser),
      .value      (LINE_BITS'(req_tdata)),
      .total      (total_ff),
      .shown      (shown_ff),
      .goal       (goal_ff),
      .tail       (tail_ff),
      .total_next (total_in),
      .shown_next (shown_in),
      .goal_next  (goal_in),
      .flags      (flags_in)
   );

   ssv_window #(.LINE_BITS(LINE_BITS)) u_window (
      .total     (s1_total_ff),
      .shown     (s1_shown_ff),
      .height    (height_ff),
      .win_begin (win_begin),
      .win_end   (win_end)
   );

   assign out_data_in = {5'd0,
                         FIELD_WIDTH'(win_end),
                         FIELD_WIDTH'(win_begin),
                         s1_flags_ff.pending,
                         s1_flags_ff.following,
                         FIELD_WIDTH'(s1_shown_ff),
                         s1_flags_ff.changed};

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff    <= HEIGHT_RESET;
         total_ff     <= '0;
         shown_ff     <= '0;
         goal_ff      <= '0;
         tail_ff      <= 1'b1;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) height_ff <= csr_wr_data;
         if (accept) begin
            total_ff <= total_in;
            shown_ff <= shown_in;
            goal_ff  <= goal_in;
            tail_ff  <= flags_in.following;
         end
         if (req_tready) s1_valid_ff <= req_tvalid;
         if (s2_ready) out_valid_ff <= s1_valid_ff;
      end
   end

   // payload stages, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_total_ff <= total_in;
         s1_shown_ff <= shown_in;
         s1_flags_ff <= flags_in;
      end
      if (s2_ready && s1_valid_ff) out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ----- test/ssv_checker.sv -----
module ssv_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ssv_pkg::HEIGHT_WIDTH-1:0]    csr_wr_data,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [ssv_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   input  logic [ssv_pkg::KIND_WIDTH-1:0]      req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [ssv_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output int                                  fail_count,
   output int                                  pending_items
);
   import ssv_pkg::*;

   // laid out to match rsp_tdata, highest field first
   typedef struct packed {
      logic [4:0]             pad;
      logic [FIELD_WIDTH-1:0] window_end;
      logic [FIELD_WIDTH-1:0] window_begin;
      logic                   pending;
      logic                   following;
      logic [FIELD_WIDTH-1:0] line;
      logic                   changed;
   } view_type;

   logic [HEIGHT_WIDTH-1:0] window_rows;
   logic [FIELD_WIDTH-1:0]  lines_held;
   logic [FIELD_WIDTH-1:0]  view_line;
   logic [FIELD_WIDTH-1:0]  target_line;
   logic                    follow_on;
   view_type                expected_views[$];
   int                      results_seen;

   task automatic flag_error(input string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      fail_count++;
   endtask

   task automatic compare_field(input string what, input int got, input int want);
      if (got != want)
         flag_error($sformatf("%s got %0d want %0d", what, got, want));
   endtask

   // one event applied to the viewport copy, result built from the new state
   task automatic advance_viewport(input logic [KIND_WIDTH-1:0] kind,
                                   input logic [FIELD_WIDTH-1:0] value,
                                   output view_type v);
      logic [FIELD_WIDTH-1:0] prev_line;
      logic [FIELD_WIDTH-1:0] last;
      logic [FIELD_WIDTH-1:0] room;
      logic [FIELD_WIDTH-1:0] gap;
      logic [FIELD_WIDTH-1:0] stride;
      logic [FIELD_WIDTH-1:0] rows;
      logic [FIELD_WIDTH-1:0] half;
      logic [FIELD_WIDTH-1:0] lim;
      logic [FIELD_WIDTH-1:0] wb;
      logic [FIELD_WIDTH-1:0] we;
      logic                   moved;
      prev_line = view_line;
      moved = 1'b0;
      last = lines_held - FIELD_WIDTH'(1);
      case (kind)
         KIND_SET_COUNT: begin
            lines_held = value;
            last = value - FIELD_WIDTH'(1);
            if (value == '0) begin
               view_line = '0;
               target_line = '0;
               follow_on = 1'b1;
            end else if (follow_on) begin
               view_line = last;
               target_line = last;
            end else begin
               if (view_line > last) view_line = last;
               if (target_line > last) target_line = last;
            end
            moved = prev_line != view_line;
         end
         KIND_FOLLOW: begin
            follow_on = 1'b1;
            if (lines_held != '0) begin
               view_line = last;
               target_line = last;
            end
         end
         KIND_UP: begin
            if (lines_held != '0) begin
               follow_on = 1'b0;
               target_line = (target_line > value) ? target_line - value : '0;
               moved = view_line != target_line;
            end
         end
         KIND_DOWN: begin
            if (lines_held != '0) begin
               follow_on = 1'b0;
               room = (target_line <= last) ? last - target_line : '0;
               target_line = target_line + ((value < room) ? value : room);
               if (view_line == target_line && target_line == last) follow_on = 1'b1;
               moved = view_line != target_line;
            end
         end
         KIND_TICK: begin
            if (view_line != target_line) begin
               gap = (view_line < target_line) ? target_line - view_line
                                               : view_line - target_line;
               stride = gap >> STEP_SHIFT;
               if (stride == '0) stride = FIELD_WIDTH'(1);
               if (stride > FIELD_WIDTH'(STEP_MAX)) stride = FIELD_WIDTH'(STEP_MAX);
               view_line = (view_line < target_line) ? view_line + stride
                                                     : view_line - stride;
            end
            // landing on the last line picks up the tail again
            if (view_line == target_line && lines_held != '0 && view_line == last)
               follow_on = 1'b1;
            moved = prev_line != view_line;
         end
         KIND_HOME: begin
            moved = view_line != '0;
            follow_on = 1'b0;
            view_line = '0;
            target_line = '0;
         end
         KIND_END: begin
            moved = lines_held != '0 && view_line != last;
            follow_on = 1'b1;
            if (lines_held != '0) begin
               view_line = last;
               target_line = last;
            end
         end
         KIND_JUMP: begin
            if (lines_held != '0) begin
               room = (value < last) ? value : last;
               moved = view_line != room;
               view_line = room;
               target_line = room;
               follow_on = 1'b0;
            end
         end
      endcase

      rows = FIELD_WIDTH'(window_rows);
      wb = '0;
      we = '0;
      if (lines_held != '0 && rows != '0) begin
         if (lines_held <= rows) begin
            we = lines_held;
         end else begin
            half = rows >> 1;
            lim = lines_held - rows;
            wb = (view_line > half) ? view_line - half : '0;
            if (wb > lim) wb = lim;
            we = wb + rows;
         end
      end

      v.pad = '0;
      v.changed = moved;
      v.line = view_line;
      v.following = follow_on;
      v.pending = view_line != target_line;
      v.window_begin = wb;
      v.window_end = we;
   endtask

   always @(posedge clock) begin
      view_type got;
      view_type want;
      if (reset) begin
         window_rows = HEIGHT_RESET;
         lines_held = '0;
         view_line = '0;
         target_line = '0;
         follow_on = 1'b1;
         fail_count = 0;
         results_seen = 0;
         expected_views.delete();
      end else begin
         if (csr_wr_en) window_rows = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = view_type'(rsp_tdata);
            if (expected_views.size() == 0) begin
               flag_error("result with no item waiting");
            end else begin
               want = expected_views.pop_front();
               compare_field("changed", int'(got.changed), int'(want.changed));
               compare_field("shown line", int'(got.line), int'(want.line));
               compare_field("follow flag", int'(got.following), int'(want.following));
               compare_field("pending flag", int'(got.pending), int'(want.pending));
               compare_field("window_begin", int'(got.window_begin),
                             int'(want.window_begin));
               compare_field("window_end", int'(got.window_end), int'(want.window_end));
               compare_field("padding", int'(got.pad), int'(want.pad));
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            advance_viewport(req_tuser, req_tdata, want);
            expected_views.push_back(want);
         end
      end
      pending_items = expected_views.size();
   end

endmodule

// ----- test/tb_top.sv -----
module tb_top;
   import ssv_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_ITEMS = 300;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [HEIGHT_WIDTH-1:0]   csr_wr_data = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;   // value_in[15:0]
   logic [KIND_WIDTH-1:0]     req_tuser = '0;   // kind[2:0]
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // changed[0], shown line[16:1], follow flag[17], pending flag[18],
   // window_begin[34:19], window_end[50:35], zero[55:51]
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   int fail_count;
   int pending_items;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asked = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int stall_cycles = 0;
   int items_sent = 0;

   smooth_scroll_viewport_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   ssv_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_items (pending_items)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus a long hold whenever one is asked for
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_taken) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_taken <= hold_asked;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("no progress for %0d cycles", STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic offer_item(input logic [KIND_WIDTH-1:0] kind,
                             input logic [REQ_DATA_WIDTH-1:0] value);
      logic ready_now;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= value;
      // ready is settled by the falling edge and holds until the next rising one
      do begin
         @(negedge clock);
         ready_now = req_tready;
         @(posedge clock);
      end while (!ready_now);
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_items != 0);
      @(posedge clock);
   endtask

   task automatic write_height(input logic [HEIGHT_WIDTH-1:0] rows);
      drain_results();
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= rows;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // mostly plausible scrolling sessions with enough ticks to finish animations
   task automatic random_item();
      int pick;
      int shape;
      logic [KIND_WIDTH-1:0]     kind;
      logic [REQ_DATA_WIDTH-1:0] value;
      pick = $urandom_range(99);
      shape = $urandom_range(9);
      value = REQ_DATA_WIDTH'($urandom);
      if (pick < 8) begin
         kind = KIND_SET_COUNT;
         if (shape == 0) value = '0;
         else if (shape == 1) value = '1;
         else if (shape > 3) value = REQ_DATA_WIDTH'($urandom_range(1, 400));
      end else if (pick < 13) begin
         kind = KIND_FOLLOW;
      end else if (pick < 43) begin
         kind = (pick < 28) ? KIND_UP : KIND_DOWN;
         if (shape == 0) value = '0;
         else if (shape == 1) value = '1;
         else if (shape > 3) value = REQ_DATA_WIDTH'($urandom_range(1, 64));
      end else if (pick < 75) begin
         kind = KIND_TICK;
      end else if (pick < 79) begin
         kind = KIND_HOME;
      end else if (pick < 83) begin
         kind = KIND_END;
      end else begin
         kind = KIND_JUMP;
         if (shape == 0) value = '1;
         else if (shape > 2) value = REQ_DATA_WIDTH'($urandom_range(0, 420));
      end
      offer_item(kind, value);
   endtask

   initial begin
      logic [HEIGHT_WIDTH-1:0] phase_rows[6];
      phase_rows[0] = 8'd0;
      phase_rows[1] = 8'd255;
      phase_rows[2] = 8'd1;
      phase_rows[3] = HEIGHT_WIDTH'($urandom_range(3, 60));
      phase_rows[4] = 8'd2;
      phase_rows[5] = HEIGHT_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty buffer: scrolls and jumps do nothing, end and count 0 restore follow
      offer_item(KIND_UP, 16'hFFFF);
      offer_item(KIND_DOWN, 16'h5555);
      offer_item(KIND_JUMP, 16'hAAAA);
      offer_item(KIND_TICK, 16'h0000);
      offer_item(KIND_END, 16'h0000);
      offer_item(KIND_HOME, 16'hFFFF);
      offer_item(KIND_SET_COUNT, 16'h0000);
      offer_item(KIND_FOLLOW, 16'h0000);
      // following count jumps to the tail, then saturating scrolls and animation
      offer_item(KIND_SET_COUNT, 16'd100);
      offer_item(KIND_UP, 16'hFFFF);
      offer_item(KIND_TICK, 16'h0000);
      offer_item(KIND_TICK, 16'h0000);
      offer_item(KIND_TICK, 16'h0000);
      offer_item(KIND_DOWN, 16'hFFFF);
      offer_item(KIND_TICK, 16'h0000);
      offer_item(KIND_JUMP, 16'hFFFF);
      offer_item(KIND_HOME, 16'h0000);
      offer_item(KIND_SET_COUNT, 16'hFFFF);
      offer_item(KIND_END, 16'h0000);
      // buffer smaller than the window
      offer_item(KIND_SET_COUNT, 16'd10);
      offer_item(KIND_JUMP, 16'd3);
      offer_item(KIND_DOWN, 16'd6);
      offer_item(KIND_TICK, 16'h0000);
      offer_item(KIND_SET_COUNT, 16'd1);
      offer_item(KIND_FOLLOW, 16'h0000);

      for (int phase = 0; phase < 6; phase++) begin
         write_height(phase_rows[phase]);
         if (phase < 2) begin
            send_idle_pct = 15;
            recv_idle_pct = 76;
         end else if (phase < 4) begin
            send_idle_pct = 76;
            recv_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // long receiver hold while the sender keeps pushing
         if (phase == 4) hold_asked <= hold_asked + 1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            random_item();
            if (n == PHASE_ITEMS / 2) drain_results();
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      $display("sent %0d events over six window heights from 0 to 255", items_sent);
      $display("with sender and receiver stalls, a long output hold and full drains");
      if (fail_count == 0 && pending_items == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, pending_items);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
